@@ design/assert_macros.svh @@
// assertion macros shared by the terminal writer modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define TMTW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define TMTW_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TMTW_ASSERT(lbl, clk, rst_n, prop)
`define TMTW_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/tmtw_pkg.sv @@
// shared types and constants of the text mode terminal writer
// used by the controller, the datapath and the top level

package tmtw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // field widths
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int CELL_W    = 16;
  localparam int CURSOR_W  = 11;
  localparam int ROW_IN_W  = 5;
  localparam int COL_IN_W  = 7;

  // reset values
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0]  CELL_RESET  = 16'h0720;

  // control bytes
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // operation codes
  typedef enum logic {
    OP_PRINT = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the incoming word
    logic exec;        // carry out the latched word
    logic read_out;    // read data is back, send the result
    logic clear_wr;    // write one cell of a clearing sweep
    logic clear_init;  // sweep uses the reset cell, not the current colour
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_read;
    logic need_scroll;
    logic clr_row_end;
    logic clr_all_end;
  } dp_status_t;

endpackage

@@ design/text_mode_terminal_writer_top.sv @@
// top level of the text mode terminal writer
// depends on tmtw_pkg, tmtw_ctrl and tmtw_dp

// Character-cell terminal of ROWS x COLUMNS 16-bit cells. After reset, busy
// stays high while the cell ram is swept to grey spaces, one cell per cycle.
// A word is taken when start is high and busy is low. A print is latched on
// accept and carried out in the exec state; its result is registered and
// strobed on done_o. A read also passes through the read state because of the
// registered ram read. A print that scrolls keeps busy high in the scroll
// state while the new bottom row is refilled through the single ram write
// port; scrolling itself is a row offset, not a copy. done_o is high for
// exactly one cycle per word and cannot be held off by the receiver.

module text_mode_terminal_writer_top #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation_i,
  input  logic [tmtw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tmtw_pkg::ROW_IN_W-1:0]    read_row_i,
  input  logic [tmtw_pkg::COL_IN_W-1:0]    read_col_i,
  input  logic                             cfg_we_i,
  input  logic [tmtw_pkg::COLOR_W-1:0]     cfg_wdata_i,
  output logic [tmtw_pkg::CURSOR_W-1:0]    cursor_pos_o,
  output logic [tmtw_pkg::CELL_W-1:0]      cell_entry_o,
  output logic                             scrolled_o,
  output logic                             done_o
);

  tmtw_pkg::ctrl_cmd_t  cmd;
  tmtw_pkg::dp_status_t status;

  // sequencer
  tmtw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // cursor, screen store and result
  tmtw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cursor_pos_o (cursor_pos_o),
    .cell_entry_o (cell_entry_o),
    .scrolled_o   (scrolled_o),
    .done_o       (done_o)
  );

endmodule

@@ design/tmtw_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies

module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tmtw_ctrl.sv @@
// controller state machine of the terminal writer
// depends on tmtw_pkg and assert_macros.svh

`include "assert_macros.svh"

module tmtw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tmtw_pkg::dp_status_t  status_i,
  output tmtw_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o
);

  tmtw_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmtw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      tmtw_pkg::ST_CLEAR: begin
        cmd_o.clear_wr   = 1'b1;
        cmd_o.clear_init = 1'b1;
        if (status_i.clr_all_end) begin
          state_d = tmtw_pkg::ST_IDLE;
        end
      end
      tmtw_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = tmtw_pkg::ST_EXEC;
        end
      end
      tmtw_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        priority if (status_i.op_read) begin
          state_d = tmtw_pkg::ST_READ;
        end else if (status_i.need_scroll) begin
          state_d = tmtw_pkg::ST_SCROLL;
        end else begin
          state_d = tmtw_pkg::ST_IDLE;
        end
      end
      tmtw_pkg::ST_READ: begin
        cmd_o.read_out = 1'b1;
        state_d        = tmtw_pkg::ST_IDLE;
      end
      tmtw_pkg::ST_SCROLL: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clr_row_end) begin
          state_d = tmtw_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // checks
  `TMTW_ASSERT(a_exec_from_idle, clk_i, rst_ni,
               (state_q == tmtw_pkg::ST_EXEC) |-> ($past(state_q) == tmtw_pkg::ST_IDLE))
  `TMTW_ASSERT(a_scroll_entry, clk_i, rst_ni,
               (state_q == tmtw_pkg::ST_SCROLL) |->
               ($past(state_q) == tmtw_pkg::ST_EXEC || $past(state_q) == tmtw_pkg::ST_SCROLL))
  `TMTW_ASSERT(a_read_after_exec, clk_i, rst_ni,
               (state_q == tmtw_pkg::ST_READ) |-> ($past(state_q) == tmtw_pkg::ST_EXEC))

endmodule

@@ design/tmtw_dp.sv @@
// datapath of the terminal writer: cursor, scroll offset, cell ram, result registers
// depends on tmtw_pkg, tmtw_ram and assert_macros.svh

`include "assert_macros.svh"

module tmtw_dp #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tmtw_pkg::ctrl_cmd_t              cmd_i,
  output tmtw_pkg::dp_status_t             status_o,
  input  logic                             operation_i,
  input  logic [tmtw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tmtw_pkg::ROW_IN_W-1:0]    read_row_i,
  input  logic [tmtw_pkg::COL_IN_W-1:0]    read_col_i,
  input  logic                             cfg_we_i,
  input  logic [tmtw_pkg::COLOR_W-1:0]     cfg_wdata_i,
  output logic [tmtw_pkg::CURSOR_W-1:0]    cursor_pos_o,
  output logic [tmtw_pkg::CELL_W-1:0]      cell_entry_o,
  output logic                             scrolled_o,
  output logic                             done_o
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW:0]   COL_LIMIT = (CW + 1)'(COLUMNS);
  localparam logic [CW:0]   TAB_STEP  = (CW + 1)'(8);
  localparam logic [CW:0]   TAB_MASK  = ~((CW + 1)'(7));
  localparam logic [RW:0]   ROW_LIMIT = (RW + 1)'(ROWS);

  // latched input word
  tmtw_pkg::op_e                   op_q;
  logic [tmtw_pkg::CHAR_W-1:0]     char_q;
  logic [tmtw_pkg::ROW_IN_W-1:0]   rrow_q;
  logic [tmtw_pkg::COL_IN_W-1:0]   rcol_q;

  // cursor, physical row of the cursor, physical row shown on top
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] prow_q, prow_d;
  logic [RW-1:0] base_q, base_d;

  // clearing sweep position
  logic [RW-1:0] clr_row_q, clr_row_d;
  logic [CW-1:0] clr_col_q, clr_col_d;

  logic [tmtw_pkg::COLOR_W-1:0] color_q;

  // result registers
  logic                           done_q;
  logic [tmtw_pkg::CURSOR_W-1:0]  cursor_pos_q;
  logic [tmtw_pkg::CELL_W-1:0]    cell_entry_q;
  logic                           scrolled_q;

  logic [CW:0]   col_ext, tab_col, inc_col;
  logic [CW-1:0] col_new;
  logic          adv, wr_char, at_bottom, need_scroll, exec_print;
  logic [RW-1:0] prow_inc, base_inc;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tmtw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic [RW-1:0]               w_row;
  logic [CW-1:0]               w_col;
  logic [RW:0]                 rd_sum;
  logic [RW-1:0]               rd_prow;
  logic                        in_range;
  logic [tmtw_pkg::CURSOR_W-1:0] pos_d;

  // latch the input word on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= tmtw_pkg::op_e'(operation_i);
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  // colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tmtw_pkg::COLOR_RESET;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  // decode of the printed byte
  assign col_ext = {1'b0, col_q};
  assign tab_col = (col_ext + TAB_STEP) & TAB_MASK;
  assign inc_col = col_ext + (CW + 1)'(1);

  always_comb begin
    adv     = 1'b0;
    wr_char = 1'b0;
    col_new = col_q;
    unique case (char_q)
      tmtw_pkg::CH_NEWLINE: adv = 1'b1;
      tmtw_pkg::CH_RETURN:  col_new = '0;
      tmtw_pkg::CH_TAB: begin
        if (tab_col >= COL_LIMIT) begin
          adv = 1'b1;
        end else begin
          col_new = CW'(tab_col);
        end
      end
      default: begin
        wr_char = 1'b1;
        if (inc_col >= COL_LIMIT) begin
          adv = 1'b1;
        end else begin
          col_new = CW'(inc_col);
        end
      end
    endcase
  end

  assign at_bottom   = (row_q == LAST_ROW);
  assign need_scroll = (op_q == tmtw_pkg::OP_PRINT) && adv && at_bottom;
  assign exec_print  = cmd_i.exec && (op_q == tmtw_pkg::OP_PRINT);
  assign prow_inc    = (prow_q == LAST_ROW) ? '0 : prow_q + RW'(1);
  assign base_inc    = (base_q == LAST_ROW) ? '0 : base_q + RW'(1);

  // cursor and sweep next state
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    prow_d    = prow_q;
    base_d    = base_q;
    clr_row_d = clr_row_q;
    clr_col_d = clr_col_q;
    if (exec_print) begin
      if (adv) begin
        col_d  = '0;
        prow_d = prow_inc;
        if (at_bottom) begin
          base_d    = base_inc;
          clr_row_d = prow_inc;
          clr_col_d = '0;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_new;
      end
    end
    if (cmd_i.clear_wr) begin
      if (clr_col_q == LAST_COL) begin
        clr_col_d = '0;
        if (cmd_i.clear_init) begin
          clr_row_d = clr_row_q + RW'(1);
        end
      end else begin
        clr_col_d = clr_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      prow_q    <= '0;
      base_q    <= '0;
      clr_row_q <= '0;
      clr_col_q <= '0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      prow_q    <= prow_d;
      base_q    <= base_d;
      clr_row_q <= clr_row_d;
      clr_col_q <= clr_col_d;
    end
  end

  // write port: clearing sweep or printed character
  assign ram_we    = cmd_i.clear_wr || (exec_print && wr_char);
  assign w_row     = cmd_i.clear_wr ? clr_row_q : prow_q;
  assign w_col     = cmd_i.clear_wr ? clr_col_q : col_q;
  assign ram_waddr = AW'(32'(w_row) * COLUMNS + 32'(w_col));

  always_comb begin
    if (cmd_i.clear_wr) begin
      ram_wdata = cmd_i.clear_init ? tmtw_pkg::CELL_RESET : {color_q, tmtw_pkg::CH_SPACE};
    end else begin
      ram_wdata = {color_q, char_q};
    end
  end

  // read port: screen row mapped through the scroll offset
  assign rd_sum    = {1'b0, RW'(rrow_q)} + {1'b0, base_q};
  assign rd_prow   = (rd_sum >= ROW_LIMIT) ? RW'(rd_sum - ROW_LIMIT) : RW'(rd_sum);
  assign ram_re    = cmd_i.exec && (op_q == tmtw_pkg::OP_READ);
  assign ram_raddr = AW'(32'(rd_prow) * COLUMNS + 32'(CW'(rcol_q)));
  assign in_range  = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLUMNS));

  tmtw_ram #(
    .WIDTH (tmtw_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result word
  assign pos_d = tmtw_pkg::CURSOR_W'(32'(row_d) * COLUMNS + 32'(col_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= exec_print || cmd_i.read_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_print || cmd_i.read_out) begin
      cursor_pos_q <= pos_d;
      cell_entry_q <= (cmd_i.read_out && in_range) ? ram_rdata : '0;
      scrolled_q   <= cmd_i.read_out ? 1'b0 : need_scroll;
    end
  end

  assign cursor_pos_o = cursor_pos_q;
  assign cell_entry_o = cell_entry_q;
  assign scrolled_o   = scrolled_q;
  assign done_o       = done_q;

  assign status_o.op_read     = (op_q == tmtw_pkg::OP_READ);
  assign status_o.need_scroll = need_scroll;
  assign status_o.clr_row_end = (clr_col_q == LAST_COL);
  assign status_o.clr_all_end = (clr_col_q == LAST_COL) && (clr_row_q == LAST_ROW);

  // checks
  `TMTW_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q)
  `TMTW_ASSERT(a_scroll_at_bottom, clk_i, rst_ni,
               (done_q && scrolled_q) |-> (row_q == LAST_ROW))
  `TMTW_NEVER(a_col_range, clk_i, rst_ni, col_ext >= COL_LIMIT)

endmodule
